### design/pat_pkg.sv
// Shared types and constants for the packed 12-bit allocation table.
// Used by pat_unpack and packed_12bit_allocation_table. No dependencies.
package pat_pkg;

  // Field widths, fixed by the item format
  localparam int ENTRY_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 3;
  localparam int BADDR_W   = 13;
  localparam int LIMIT_W   = 13;
  localparam int PAIR_W    = 2 * BYTE_W;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 13;

  // Default number of entries
  localparam int EntryCountDef = 4096;

  // Register reset values
  localparam logic [ENTRY_W-1:0] SEARCH_START_RST = 12'd2;
  localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RST = 13'd4096;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_READ_ENTRY  = 3'd0,
    OP_WRITE_ENTRY = 3'd1,
    OP_FIND_FREE   = 3'd2,
    OP_READ_BYTE   = 3'd3,
    OP_WRITE_BYTE  = 3'd4
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_START = 1'b0,
    CFG_SEARCH_LIMIT = 1'b1
  } cfg_idx_e;

  // Request to the field unit: byte pair around an entry
  typedef struct packed {
    logic [PAIR_W-1:0]  pair;
    logic               odd;
    logic [ENTRY_W-1:0] value;
  } fld_req_t;

  // Answer from the field unit
  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [PAIR_W-1:0]  merged;
  } fld_rsp_t;

endpackage

### design/pat_unpack.sv
// Field unit: extracts a 12-bit entry from its little-endian byte pair and
// merges a new value into the pair. Depends on pat_pkg.
module pat_unpack (
  input  pat_pkg::fld_req_t req_i,
  output pat_pkg::fld_rsp_t rsp_o
);
  import pat_pkg::*;

  // Odd entries sit in the upper 12 bits, even ones in the lower 12
  always_comb begin
    if (req_i.odd) begin
      rsp_o.entry  = req_i.pair[PAIR_W-1:PAIR_W-ENTRY_W];
      rsp_o.merged = {req_i.value, req_i.pair[PAIR_W-ENTRY_W-1:0]};
    end else begin
      rsp_o.entry  = req_i.pair[ENTRY_W-1:0];
      rsp_o.merged = {req_i.pair[PAIR_W-1:ENTRY_W], req_i.value};
    end
  end

endmodule

### design/packed_12bit_allocation_table.sv
// Top level of the packed 12-bit allocation table: byte store, sequencer,
// output register. Depends on pat_pkg and pat_unpack.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o  | operation, entry_index,
//           |           |                        | entry_value, byte_address, byte_data
//   out     | output    | out_valid_o / out_stall_i| read_value, found
//   cfg     | input     | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// One item at a time; the single-port byte memory sets the pace. Find free
// examines one entry after another (one address add, two byte reads, one
// compare each) and stops at the first free entry or at the search limit.
// Reset returns control to idle and configuration to its reset values;
// the byte store is not cleared. A stalled result stays in the output
// register while the next item is taken.
module packed_12bit_allocation_table #(
  parameter int ENTRY_COUNT = pat_pkg::EntryCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [pat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pat_pkg::CFG_W-1:0]   cfg_data_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pat_pkg::OP_W-1:0]    operation_i,
  input  logic [pat_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic [pat_pkg::ENTRY_W-1:0] entry_value_i,
  input  logic [pat_pkg::BADDR_W-1:0] byte_address_i,
  input  logic [pat_pkg::BYTE_W-1:0]  byte_data_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pat_pkg::ENTRY_W-1:0] read_value_o,
  output logic                        found_o
);
  import pat_pkg::*;

  localparam int StoreBytes = (ENTRY_COUNT * 3 + 1) / 2;
  localparam int AW         = $clog2(StoreBytes);

  localparam logic [LIMIT_W-1:0] EntryCountW = LIMIT_W'(ENTRY_COUNT);
  localparam logic [BADDR_W:0]   StoreBytesW = (BADDR_W + 1)'(StoreBytes);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_RD_LO,
    S_RD_HI,
    S_EVAL,
    S_WR_LO,
    S_BYTE_RD,
    S_BYTE_EV,
    S_BYTE_WR,
    S_DONE
  } state_e;

  state_e               state_q;
  op_e                  op_q;
  logic [LIMIT_W-1:0]   n_q;
  logic [AW-1:0]        addr_q;
  logic [ENTRY_W-1:0]   val_q;
  logic [BYTE_W-1:0]    lo_q;
  logic [ENTRY_W-1:0]   res_q;
  logic                 hit_q;
  logic [ENTRY_W-1:0]   start_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 out_valid_q;
  logic [ENTRY_W-1:0]   read_value_q;
  logic                 found_q;

  // byte store
  logic [BYTE_W-1:0]    mem [StoreBytes];
  logic [BYTE_W-1:0]    rdata_q;
  logic                 mem_we;
  logic [BYTE_W-1:0]    mem_wdata;

  logic                 in_accept;
  logic                 out_free;
  logic [LIMIT_W-1:0]   stop;
  logic [LIMIT_W-1:0]   n_next;
  logic [LIMIT_W-1:0]   base_sum;
  logic [LIMIT_W-1:0]   idx_ext;
  logic [BADDR_W:0]     baddr_ext;
  fld_req_t             fld_req;
  fld_rsp_t             fld_rsp;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign stop      = (limit_q > EntryCountW) ? EntryCountW : limit_q;
  assign n_next    = n_q + LIMIT_W'(1);
  assign base_sum  = n_q + (n_q >> 1);
  assign idx_ext   = LIMIT_W'(entry_index_i);
  assign baddr_ext = (BADDR_W + 1)'(byte_address_i);

  // Field unit on the byte pair just read
  assign fld_req.pair  = {rdata_q, lo_q};
  assign fld_req.odd   = n_q[0];
  assign fld_req.value = val_q;

  pat_unpack u_unpack (
    .req_i (fld_req),
    .rsp_o (fld_rsp)
  );

  // Select the store write
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = val_q[BYTE_W-1:0];
    unique case (state_q)
      S_EVAL: begin
        mem_we    = (op_q == OP_WRITE_ENTRY);
        mem_wdata = fld_rsp.merged[PAIR_W-1:BYTE_W];
      end
      S_WR_LO: begin
        mem_we    = 1'b1;
        mem_wdata = lo_q;
      end
      S_BYTE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = val_q[BYTE_W-1:0];
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  // Single-port store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_READ_ENTRY;
      n_q          <= '0;
      addr_q       <= '0;
      val_q        <= '0;
      lo_q         <= '0;
      res_q        <= '0;
      hit_q        <= 1'b0;
      start_q      <= SEARCH_START_RST;
      limit_q      <= SEARCH_LIMIT_RST;
      out_valid_q  <= 1'b0;
      read_value_q <= '0;
      found_q      <= 1'b0;
    end else begin
      // take configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SEARCH_START: start_q <= cfg_data_i[ENTRY_W-1:0];
          CFG_SEARCH_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
          default:          ;
        endcase
      end

      // drop a taken result unless a new one replaces it
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            op_q  <= op_e'(operation_i);
            res_q <= '0;
            hit_q <= 1'b0;
            priority case (operation_i)
              OP_READ_ENTRY, OP_WRITE_ENTRY: begin
                n_q   <= idx_ext;
                val_q <= entry_value_i;
                state_q <= (idx_ext < EntryCountW) ? S_BASE : S_DONE;
              end
              OP_FIND_FREE: begin
                n_q     <= LIMIT_W'(start_q);
                state_q <= (LIMIT_W'(start_q) < stop) ? S_BASE : S_DONE;
              end
              OP_READ_BYTE, OP_WRITE_BYTE: begin
                addr_q <= byte_address_i[AW-1:0];
                val_q  <= ENTRY_W'(byte_data_i);
                if (baddr_ext < StoreBytesW) begin
                  state_q <= (operation_i == OP_READ_BYTE) ? S_BYTE_RD : S_BYTE_WR;
                end else begin
                  state_q <= S_DONE;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        // entry n starts at byte n + n/2
        S_BASE: begin
          addr_q  <= base_sum[AW-1:0];
          state_q <= S_RD_LO;
        end
        S_RD_LO: begin
          addr_q  <= addr_q + AW'(1);
          state_q <= S_RD_HI;
        end
        S_RD_HI: begin
          lo_q    <= rdata_q;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          priority case (op_q)
            OP_WRITE_ENTRY: begin
              // upper byte written now, lower byte next
              lo_q    <= fld_rsp.merged[BYTE_W-1:0];
              addr_q  <= addr_q - AW'(1);
              state_q <= S_WR_LO;
            end
            OP_FIND_FREE: begin
              if (fld_rsp.entry == '0) begin
                res_q   <= n_q[ENTRY_W-1:0];
                hit_q   <= 1'b1;
                state_q <= S_DONE;
              end else begin
                n_q     <= n_next;
                state_q <= (n_next < stop) ? S_BASE : S_DONE;
              end
            end
            default: begin
              res_q   <= fld_rsp.entry;
              state_q <= S_DONE;
            end
          endcase
        end
        S_WR_LO: begin
          state_q <= S_DONE;
        end
        S_BYTE_RD: begin
          state_q <= S_BYTE_EV;
        end
        S_BYTE_EV: begin
          res_q   <= ENTRY_W'(rdata_q);
          state_q <= S_DONE;
        end
        S_BYTE_WR: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hand the result over once the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            read_value_q <= res_q;
            found_q      <= hit_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign found_o      = found_q;

endmodule
